>>> sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("skvt_assertions: property violated");

// Same, on the block's own clock and reset names.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clk, arst_n, prop)

`endif

>>> sv/skvt_pkg.sv
package skvt_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	// Fixed widths of the stream fields.
	localparam int MODE_W     = 3;
	localparam int FIELD_W    = 32;
	localparam int RANK_W     = 6;
	localparam int COUNT_W    = 7;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT    = 3'd0,
		MODE_UPDATE    = 3'd1,
		MODE_UPSERT    = 3'd2,
		MODE_ERASE     = 3'd3,
		MODE_GET_KEY   = 3'd4,
		MODE_GET_RANK  = 3'd5,
		MODE_CONTAINS  = 3'd6
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} ctrl_state_t;

	// Command broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic capture;  // compare the new request against the stored entry
		logic by_rank;  // select by position rather than by key
		logic apply;    // commit the request decided in the compare cycle
		logic ins;      // open a slot and shift the upper entries up
		logic ers;      // close the slot and shift the upper entries down
		logic upd;      // overwrite the value of the matching entry
	} cell_cmd_t;

endpackage

>>> sv/skvt_cell.sv
module skvt_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int CW         = 7,
	parameter int INDEX      = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  skvt_pkg::cell_cmd_t       cmd,
	input  logic [CW-1:0]             count,
	input  logic [KEY_BITS-1:0]       req_key,
	input  logic [VALUE_BITS-1:0]     req_value,
	input  logic [skvt_pkg::RANK_W-1:0] req_rank,
	input  logic                      left_lt,
	input  logic [KEY_BITS-1:0]       left_key,
	input  logic [VALUE_BITS-1:0]     left_value,
	input  logic [KEY_BITS-1:0]       right_key,
	input  logic [VALUE_BITS-1:0]     right_value,
	output logic [KEY_BITS-1:0]       key_q,
	output logic [VALUE_BITS-1:0]     value_q,
	output logic                      lt_s1,
	output logic                      eq_s1,
	output logic                      hit_s1
);
	import skvt_pkg::*;

	localparam int MW = (CW > RANK_W) ? CW : RANK_W;

	logic in_range;
	logic eq_now;
	logic rank_now;

	// Only slots below the entry count hold live entries.
	assign in_range = CW'(INDEX) < count;
	assign eq_now   = in_range && (key_q == req_key);
	assign rank_now = in_range && (MW'(INDEX) == MW'(req_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1  <= 1'b0;
			eq_s1  <= 1'b0;
			hit_s1 <= 1'b0;
		end else if (cmd.capture) begin
			lt_s1  <= in_range && (key_q < req_key);
			eq_s1  <= eq_now;
			hit_s1 <= cmd.by_rank ? rank_now : eq_now;
		end
	end

	// The live entries form a sorted prefix, so the less-than flags form a
	// prefix too: the slot of the request is the first cell whose flag is low.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (cmd.ins) begin
				if (!left_lt) begin
					key_q   <= left_key;
					value_q <= left_value;
				end else if (!lt_s1) begin
					key_q   <= req_key;
					value_q <= req_value;
				end
			end else if (cmd.ers) begin
				if (!lt_s1) begin
					key_q   <= right_key;
					value_q <= right_value;
				end
			end else if (cmd.upd && eq_s1) begin
				value_q <= req_value;
			end
		end
	end

endmodule

>>> sv/sorted_key_value_table.sv
// Sorted key-value table: up to CAPACITY entries with unique keys, kept in
// ascending unsigned key order in a row of cells, one entry per cell. Each
// request on the slave stream (insert, update, insert-or-update, erase, get by
// key, get by rank, contains) produces exactly one result transaction on the
// master stream with a success flag, a key, a value and the entry count after
// the request. On the edge that accepts a request every cell compares its
// entry against the key; once the output register can take the result, all
// cells shift or update together and the result is loaded into the output
// register. No new request is taken until that shift is done. A new request
// is taken while an earlier result still waits in the output register; the
// shift cycle waits only when that register is still full and not being
// drained.
// No clearing pass is needed after reset: the entry count starts at zero and
// cells at or above the count are never reported.
module sorted_key_value_table #(
	parameter int CAPACITY   = skvt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = skvt_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = skvt_pkg::DEF_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// Fields from bit 0: key[31:0], value[63:32], rank[69:64], zero pad.
	input  logic [skvt_pkg::IN_DATA_W-1:0]   s_tdata,
	// Fields from bit 0: mode[2:0].
	input  logic [skvt_pkg::MODE_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// Fields from bit 0: found_key[31:0], found_value[63:32],
	// entry_count[70:64], zero pad.
	output logic [skvt_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Fields from bit 0: ok[0].
	output logic [0:0]                       m_tuser
);
	import skvt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// Request fields as they arrive on the slave stream. Keys and values are
	// held at the configured widths throughout the table.
	logic [KEY_BITS-1:0]   in_key;
	logic [VALUE_BITS-1:0] in_value;
	logic [RANK_W-1:0]     in_rank;
	mode_t                 in_mode;

	assign in_key   = KEY_BITS'(s_tdata[FIELD_W-1:0]);
	assign in_value = VALUE_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]);
	assign in_rank  = s_tdata[2*FIELD_W+RANK_W-1:2*FIELD_W];
	assign in_mode  = mode_t'(s_tuser);

	// The request is held for the shift cycle.
	mode_t                 mode_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;

	logic [CW-1:0] count_q;
	ctrl_state_t   state_q, state_d;
	cell_cmd_t     cmd;
	logic          accept;
	logic          fire;

	// Result register on the master side.
	logic               m_valid_q;
	logic               ok_q;
	logic [FIELD_W-1:0] fkey_q;
	logic [FIELD_W-1:0] fvalue_q;
	logic [COUNT_W-1:0] fcount_q;

	// Cell row wiring.
	logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
	logic [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0]   lt_vec;
	logic [CAPACITY-1:0]   eq_vec;
	logic [CAPACITY-1:0]   hit_vec;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= in_mode;
			key_s1   <= in_key;
			value_s1 <= in_value;
		end
	end

	// Controller: idle until a request is accepted, then commit it as soon as
	// the output register is free to take the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic present;
	logic full;
	logic may_ins;
	logic may_upd;
	logic do_ins;
	logic do_upd;
	logic do_ers;

	assign present = |eq_vec;
	assign full    = count_q == CW'(CAPACITY);
	assign may_ins = mode_s1 inside {MODE_INSERT, MODE_UPSERT};
	assign may_upd = mode_s1 inside {MODE_UPDATE, MODE_UPSERT};
	assign do_ins  = may_ins && !present && !full;
	assign do_upd  = may_upd && present;
	assign do_ers  = (mode_s1 == MODE_ERASE) && present;

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		fire        = 1'b0;
		cmd         = '0;
		cmd.by_rank = in_mode == MODE_GET_RANK;
		cmd.ins     = do_ins;
		cmd.ers     = do_ers;
		cmd.upd     = do_upd;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (!m_valid_q || m_tready) begin
					fire      = 1'b1;
					cmd.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The row of cells. Cell zero always sees a lower neighbor below the key,
	// and the top cell keeps its own entry when the row shifts down.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  left_lt;
		logic [KEY_BITS-1:0]   left_key;
		logic [VALUE_BITS-1:0] left_value;
		logic [KEY_BITS-1:0]   right_key;
		logic [VALUE_BITS-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_key   = key_s1;
			assign left_value = value_s1;
		end else begin : g_inner
			assign left_lt    = lt_vec[i-1];
			assign left_key   = cell_key[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key   = cell_key[i];
			assign right_value = cell_value[i];
		end else begin : g_lower
			assign right_key   = cell_key[i+1];
			assign right_value = cell_value[i+1];
		end

		skvt_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS),
			.CW        (CW),
			.INDEX     (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.count      (count_q),
			.req_key    (cmd.capture ? in_key : key_s1),
			.req_value  (value_s1),
			.req_rank   (in_rank),
			.left_lt    (left_lt),
			.left_key   (left_key),
			.left_value (left_value),
			.right_key  (right_key),
			.right_value(right_value),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.lt_s1      (lt_vec[i]),
			.eq_s1      (eq_vec[i]),
			.hit_s1     (hit_vec[i])
		);
	end

	// At most one cell flags a hit, so the selected entry is an AND-OR of the
	// row; with no hit it reads as zero.
	logic [KEY_BITS-1:0]   sel_key;
	logic [VALUE_BITS-1:0] sel_value;

	always_comb begin
		sel_key   = '0;
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_key   = sel_key   | ({KEY_BITS{hit_vec[i]}}   & cell_key[i]);
			sel_value = sel_value | ({VALUE_BITS{hit_vec[i]}} & cell_value[i]);
		end
	end

	// Result of the committed request. The value of an erased entry is read
	// before the row closes the gap, since both happen on the same edge.
	logic                  res_ok;
	logic [KEY_BITS-1:0]   res_key;
	logic [VALUE_BITS-1:0] res_value;
	logic [CW-1:0]         count_d;

	always_comb begin
		res_ok    = 1'b0;
		res_key   = key_s1;
		res_value = '0;
		case (mode_s1)
			MODE_INSERT, MODE_UPDATE, MODE_UPSERT: begin
				res_ok    = do_ins || do_upd;
				res_value = (do_ins || do_upd) ? value_s1 : sel_value;
			end
			MODE_ERASE, MODE_GET_KEY, MODE_CONTAINS: begin
				res_ok    = present;
				res_value = sel_value;
			end
			MODE_GET_RANK: begin
				res_ok    = |hit_vec;
				res_key   = sel_key;
				res_value = sel_value;
			end
			default: begin
				res_key = '0;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_ers) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q   <= count_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q     <= res_ok;
			fkey_q   <= FIELD_W'(res_key);
			fvalue_q <= FIELD_W'(res_value);
			fcount_q <= COUNT_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {{(OUT_DATA_W - 2*FIELD_W - COUNT_W){1'b0}}, fcount_q, fvalue_q, fkey_q};

endmodule

>>> sv/skvt_checker.sv
`include "assert_macros.svh"

module skvt_assertions #(
	parameter int CAPACITY = skvt_pkg::DEF_CAPACITY
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [skvt_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic [skvt_pkg::MODE_W-1:0]      s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [skvt_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [0:0]                       m_tuser
);
	import skvt_pkg::*;

	// A stalled result holds still.
	`ASSERT_STD(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

	// The table takes one request at a time: no request in the shift cycle.
	`ASSERT_STD(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)

	// A fresh result must trace back to an accepted request.
	`ASSERT_STD(a_result_follows, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

	// The reported count never exceeds the capacity; the check is skipped for capacities above 127.
	`ASSERT_STD(a_count_bound, m_tvalid |-> ((CAPACITY > 127) || (m_tdata[70:64] <= CAPACITY)))

endmodule

bind sorted_key_value_table skvt_assertions #(.CAPACITY(CAPACITY)) u_skvt_assertions (.*);
